// ===== sv/duplicate_frame_detector_assert.svh =====
// Assertion macros for the duplicate frame detector.
// Used by the top level; needs a clk and an arst_n in scope.
`ifndef DUPLICATE_FRAME_DETECTOR_ASSERT_SVH
`define DUPLICATE_FRAME_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define DFD_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("dfd check failed");
`define DFD_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("dfd check failed");
`else
`define DFD_ASSERT(label, expr)
`define DFD_ASSERT_NEXT(label, cond, expr)
`endif
`endif

// ===== sv/dfd_pkg.sv =====
// Shared types and constants for the duplicate frame detector.
// No dependencies.
package dfd_pkg;
	// Table depth; the ring addressing wraps by truncation, so it is a power of two.
	localparam int TABLE_DEPTH = 64;
	localparam int K_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ENTRY_W = 128;

	localparam logic [2:0] REQ_INSERT = 3'd0;
	localparam logic [2:0] REQ_QUERY = 3'd1;
	localparam logic [2:0] REQ_REMOVE = 3'd2;
	localparam logic [2:0] REQ_CLEAR = 3'd3;
	localparam logic [2:0] REQ_TICK = 3'd4;

	localparam logic CFG_EXPIRY = 1'b0;
	localparam logic CFG_GAP = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_QWALK,
		ST_RWALK,
		ST_TWALK,
		ST_COMPACT,
		ST_APPLY,
		ST_INSERT,
		ST_REPLY
	} state_t;
endpackage

// ===== sv/dfd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module dfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== sv/duplicate_frame_detector.sv =====
// Duplicate frame detector top level: control sequencer around one entry RAM.
// Depends on dfd_pkg, dfd_ram and duplicate_frame_detector_assert.svh.
//
//  channel  | direction | content
//  s_*      | in        | request word: req_type, frame_source, frame_seq, now_ms
//  m_*      | out       | reply word: is_duplicate, accepted, entries_held
//  cfg_*    | in        | register write: expiry_ms (0), max_index_gap (1)
//
// A walk reads at most live entries, one read a cycle, from the registered read
// port. When entries are deleted from the middle, a compaction pass follows that
// reads again from entry lo on, lo being the count dropped from the oldest end.
// Apply, insert and reply follow as states of their own; both passes are bound by
// the single read port of the entry RAM. Reset clears the state, the pointers and
// count, the mask, the output valid and the config registers. One request is
// in flight at a time; a finished reply waits in the output register while the
// next word is taken.
`include "duplicate_frame_detector_assert.svh"
module duplicate_frame_detector (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// req_type[2:0], frame_source[34:3], frame_seq[66:35], now_ms[130:67]
	input  logic [135:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// is_duplicate[0], accepted[1], entries_held[8:2]
	output logic [15:0]  m_tdata,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_wdata
);
	localparam int KW = dfd_pkg::K_W;
	localparam int CW = dfd_pkg::CNT_W;
	localparam int DP = dfd_pkg::TABLE_DEPTH;

	dfd_pkg::state_t state_q, state_d;
	logic [2:0]  req_q;
	logic [31:0] src_q, seq_q;
	logic [63:0] now_q;
	logic [31:0] expiry_q, gap_q;
	logic [KW-1:0] oldest_q, oldest_d;
	logic [CW-1:0] live_q, live_d;
	logic [DP-1:0] mask_q, mask_d;
	logic [CW-1:0] lo_q, lo_d;
	logic dup_q, dup_d, acc_q, acc_d;
	logic [KW-1:0] iss_k_q, iss_k_d;
	logic [CW-1:0] iss_left_q, iss_left_d;
	logic ev_vld_q, ev_vld_d;
	logic [KW-1:0] ev_k_q, ev_k_d;
	logic [CW-1:0] wr_k_q, wr_k_d;
	logic m_tvalid_q, out_load;
	logic [15:0] m_tdata_q;

	logic ram_we, ram_re;
	logic [KW-1:0] ram_waddr;
	logic [dfd_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

	logic [31:0] e_src, e_seq, e_gap;
	logic [63:0] e_age;
	logic e_expired, e_same, e_exact, e_far, ev_last_up, ev_last_dn;
	logic accept;

	dfd_ram #(.WIDTH(dfd_pkg::ENTRY_W), .DEPTH(DP)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(ram_re), .raddr(oldest_q + iss_k_q), .rdata(ram_rdata)
	);

	assign e_src = ram_rdata[31:0];
	assign e_seq = ram_rdata[63:32];
	assign e_age = now_q - ram_rdata[127:64];
	assign e_expired = e_age > {32'd0, expiry_q};
	assign e_same = (e_src == src_q);
	assign e_exact = e_same && (e_seq == seq_q);
	assign e_gap = (e_seq > seq_q) ? (e_seq - seq_q) : (seq_q - e_seq);
	assign e_far = e_gap > gap_q;
	assign ev_last_dn = (ev_k_q == '0);
	assign ev_last_up = ({1'b0, ev_k_q} == (live_q - 1'b1));

	assign s_tready = (state_q == dfd_pkg::ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	always_comb begin
		state_d = state_q;
		oldest_d = oldest_q;
		live_d = live_q;
		mask_d = mask_q;
		lo_d = lo_q;
		dup_d = dup_q;
		acc_d = acc_q;
		iss_k_d = iss_k_q;
		iss_left_d = iss_left_q;
		ev_vld_d = 1'b0;
		ev_k_d = iss_k_q;
		wr_k_d = wr_k_q;
		ram_re = 1'b0;
		ram_we = 1'b0;
		ram_waddr = oldest_q + wr_k_q[KW-1:0];
		ram_wdata = ram_rdata;
		out_load = 1'b0;

		// Walk states issue one read a cycle; its data arrives on ev_* in the cycle after.
		if ((state_q == dfd_pkg::ST_QWALK || state_q == dfd_pkg::ST_RWALK ||
				state_q == dfd_pkg::ST_TWALK || state_q == dfd_pkg::ST_COMPACT) &&
				iss_left_q != '0) begin
			ram_re = 1'b1;
			ev_vld_d = 1'b1;
			iss_left_d = iss_left_q - 1'b1;
			iss_k_d = (state_q == dfd_pkg::ST_QWALK) ? iss_k_q - 1'b1 : iss_k_q + 1'b1;
		end

		case (state_q)
			dfd_pkg::ST_IDLE: begin
				if (accept) begin
					mask_d = '0;
					lo_d = '0;
					dup_d = 1'b0;
					acc_d = 1'b0;
					iss_left_d = live_q;
					iss_k_d = (s_tdata[2:0] == dfd_pkg::REQ_INSERT ||
						s_tdata[2:0] == dfd_pkg::REQ_QUERY) ?
						KW'(live_q - 1'b1) : '0;
					case (s_tdata[2:0])
						dfd_pkg::REQ_INSERT,
						dfd_pkg::REQ_QUERY: begin
							state_d = (live_q == '0) ? dfd_pkg::ST_APPLY : dfd_pkg::ST_QWALK;
						end
						dfd_pkg::REQ_REMOVE: begin
							state_d = (live_q == '0) ? dfd_pkg::ST_REPLY : dfd_pkg::ST_RWALK;
						end
						dfd_pkg::REQ_TICK: begin
							state_d = (live_q == '0) ? dfd_pkg::ST_REPLY : dfd_pkg::ST_TWALK;
						end
						dfd_pkg::REQ_CLEAR: begin
							oldest_d = oldest_q + live_q[KW-1:0];
							live_d = '0;
							state_d = dfd_pkg::ST_REPLY;
						end
						default: begin
							state_d = dfd_pkg::ST_REPLY;
						end
					endcase
				end
			end
			dfd_pkg::ST_QWALK: begin
				if (ev_vld_q) begin
					if (e_expired) begin
						lo_d = CW'(ev_k_q) + 1'b1;
					end else if (e_exact) begin
						dup_d = 1'b1;
					end else if (e_same && e_far) begin
						mask_d[ev_k_q] = 1'b1;
					end
					if (e_expired || e_exact || ev_last_dn) begin
						iss_left_d = live_q - lo_d;
						iss_k_d = lo_d[KW-1:0];
						wr_k_d = lo_d;
						ev_vld_d = 1'b0;
						state_d = (mask_d != '0) ? dfd_pkg::ST_COMPACT : dfd_pkg::ST_APPLY;
					end
				end
			end
			dfd_pkg::ST_RWALK: begin
				if (ev_vld_q) begin
					if (e_exact) begin
						mask_d[ev_k_q] = 1'b1;
						acc_d = 1'b1;
						iss_left_d = live_q;
						iss_k_d = '0;
						wr_k_d = '0;
						ev_vld_d = 1'b0;
						state_d = dfd_pkg::ST_COMPACT;
					end else if (ev_last_up) begin
						state_d = dfd_pkg::ST_APPLY;
					end
				end
			end
			dfd_pkg::ST_TWALK: begin
				if (ev_vld_q) begin
					if (!e_expired) begin
						lo_d = CW'(ev_k_q);
						state_d = dfd_pkg::ST_APPLY;
					end else if (ev_last_up) begin
						lo_d = live_q;
						state_d = dfd_pkg::ST_APPLY;
					end
				end
			end
			dfd_pkg::ST_COMPACT: begin
				// Kept entries slide toward the oldest end; the write never passes the read.
				if (ev_vld_q) begin
					if (!mask_q[ev_k_q]) begin
						ram_we = 1'b1;
						wr_k_d = wr_k_q + 1'b1;
					end
					if (ev_last_up) begin
						live_d = wr_k_d;
						mask_d = '0;
						state_d = dfd_pkg::ST_APPLY;
					end
				end
			end
			dfd_pkg::ST_APPLY: begin
				oldest_d = oldest_q + lo_q[KW-1:0];
				live_d = live_q - lo_q;
				state_d = (req_q == dfd_pkg::REQ_INSERT && !dup_q) ?
					dfd_pkg::ST_INSERT : dfd_pkg::ST_REPLY;
			end
			dfd_pkg::ST_INSERT: begin
				// When full the oldest slot is evicted, and that is the slot written.
				ram_we = 1'b1;
				ram_waddr = oldest_q + live_q[KW-1:0];
				ram_wdata = {now_q, seq_q, src_q};
				acc_d = 1'b1;
				if (live_q == CW'(DP)) begin
					oldest_d = oldest_q + 1'b1;
				end else begin
					live_d = live_q + 1'b1;
				end
				state_d = dfd_pkg::ST_REPLY;
			end
			dfd_pkg::ST_REPLY: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d = dfd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dfd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dfd_pkg::ST_IDLE;
			oldest_q <= '0;
			live_q <= '0;
			mask_q <= '0;
			ev_vld_q <= 1'b0;
			iss_left_q <= '0;
			m_tvalid_q <= 1'b0;
			expiry_q <= '0;
			gap_q <= '0;
		end else begin
			state_q <= state_d;
			oldest_q <= oldest_d;
			live_q <= live_d;
			mask_q <= mask_d;
			ev_vld_q <= ev_vld_d;
			iss_left_q <= iss_left_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == dfd_pkg::CFG_EXPIRY) begin
					expiry_q <= cfg_wdata;
				end else begin
					gap_q <= cfg_wdata;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= lo_d;
		dup_q <= dup_d;
		acc_q <= acc_d;
		iss_k_q <= iss_k_d;
		ev_k_q <= ev_k_d;
		wr_k_q <= wr_k_d;
		if (accept) begin
			req_q <= s_tdata[2:0];
			src_q <= s_tdata[34:3];
			seq_q <= s_tdata[66:35];
			now_q <= s_tdata[130:67];
		end
		if (out_load) begin
			m_tdata_q <= {7'd0, live_q, acc_q, dup_q};
		end
	end

	`DFD_ASSERT(a_live_bound, live_q <= CW'(DP))
	`DFD_ASSERT(a_compact_order,
		!(state_q == dfd_pkg::ST_COMPACT && ev_vld_q) || (wr_k_q <= CW'(ev_k_q)))
	`DFD_ASSERT_NEXT(a_busy_after_accept, accept, state_q != dfd_pkg::ST_IDLE)
endmodule

// ===== verif/tb_duplicate_frame_detector.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for duplicate_frame_detector: random stream traffic on both sides.
// It predicts every reply with a small scoreboard and compares the replies field by field.
// Depends on dfd_pkg and the duplicate_frame_detector RTL.

class dfd_scoreboard;
	typedef struct {
		logic [31:0] source;
		logic [31:0] seq;
		logic [63:0] stamp;
	} frame_entry_t;
	typedef struct {
		logic       dup;
		logic       acc;
		logic [6:0] held;
	} reply_t;

	frame_entry_t window[$];
	reply_t       replies_due[$];
	logic [31:0]  expiry_ms;
	logic [31:0]  max_gap;
	int           mismatches;

	function new();
		expiry_ms = 0;
		max_gap = 0;
		mismatches = 0;
	endfunction

	function int pending();
		return replies_due.size();
	endfunction

	function void set_reg(logic idx, logic [31:0] val);
		if (idx == dfd_pkg::CFG_EXPIRY)
			expiry_ms = val;
		else
			max_gap = val;
	endfunction

	function bit aged_out(int k, logic [63:0] now);
		logic [63:0] age;
		age = now - window[k].stamp;
		return age > {32'd0, expiry_ms};
	endfunction

	// Walks newest to oldest; the first expired entry takes every older one with it.
	function bit walk_for_match(logic [31:0] src, logic [31:0] seq, logic [63:0] now);
		int k;
		logic [31:0] seq_gap;
		k = window.size();
		while (k > 0) begin
			k--;
			if (aged_out(k, now)) begin
				for (int i = 0; i <= k; i++)
					void'(window.pop_front());
				return 0;
			end
			if (window[k].source == src) begin
				if (window[k].seq == seq)
					return 1;
				seq_gap = (window[k].seq > seq) ? window[k].seq - seq : seq - window[k].seq;
				if (seq_gap > max_gap)
					window.delete(k);
			end
		end
		return 0;
	endfunction

	function void note_request(logic [2:0] kind, logic [31:0] src, logic [31:0] seq,
		logic [63:0] now);
		reply_t r;
		frame_entry_t e;
		r.dup = 0;
		r.acc = 0;
		case (kind)
			dfd_pkg::REQ_INSERT: begin
				if (walk_for_match(src, seq, now)) begin
					r.dup = 1;
				end else begin
					if (window.size() >= dfd_pkg::TABLE_DEPTH)
						void'(window.pop_front());
					e.source = src;
					e.seq = seq;
					e.stamp = now;
					window.push_back(e);
					r.acc = 1;
				end
			end
			dfd_pkg::REQ_QUERY: r.dup = walk_for_match(src, seq, now);
			dfd_pkg::REQ_REMOVE: begin
				for (int k = 0; k < window.size(); k++) begin
					if (window[k].source == src && window[k].seq == seq) begin
						window.delete(k);
						r.acc = 1;
						break;
					end
				end
			end
			dfd_pkg::REQ_CLEAR: window.delete();
			dfd_pkg::REQ_TICK: begin
				while (window.size() > 0 && aged_out(0, now))
					void'(window.pop_front());
			end
			default: ;
		endcase
		r.held = 7'(window.size());
		replies_due.push_back(r);
	endfunction

	function void check_reply(logic [15:0] word);
		reply_t r;
		if (replies_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected reply word %h", word);
			return;
		end
		r = replies_due.pop_front();
		if (word[0] !== r.dup || word[1] !== r.acc || word[8:2] !== r.held) begin
			mismatches++;
			if (mismatches <= 10)
				$display("reply mismatch: expected dup=%0d acc=%0d held=%0d",
					r.dup, r.acc, r.held,
					", got dup=%0d acc=%0d held=%0d", word[0], word[1], word[8:2]);
		end
	endfunction
endclass

module tb_duplicate_frame_detector;
	localparam int CYCLE_LIMIT = 2000000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [15:0]  m_tdata;
	logic         cfg_we;
	logic         cfg_index;
	logic [31:0]  cfg_wdata;

	dfd_scoreboard sb;
	bit            calm;
	int            cycles = 0;
	logic [63:0]   clock_ms;
	logic [31:0]   recent_src[8];
	logic [31:0]   recent_seq[8];

	duplicate_frame_detector i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL duplicate_frame_detector");
			$finish;
		end
	end

	function int draw_gap();
		return calm ? 0 : $urandom_range(0, 16);
	endfunction

	task automatic send_word(logic [2:0] kind, logic [31:0] src, logic [31:0] seq,
		logic [63:0] now);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {5'd0, now, seq, src, kind};
		do @(posedge clk); while (!s_tready);
		sb.note_request(kind, src, seq, now);
	endtask

	// Drops valid and lets the block drain before anything else happens.
	task automatic drain();
		s_tvalid <= 0;
		repeat (4) @(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		drain();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	task automatic random_phase(int count, int adv_max, int src_pool);
		int r;
		int slot;
		logic [2:0] kind;
		logic [31:0] src;
		logic [31:0] seq;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0)
				calm = ($urandom_range(0, 3) == 0);
			clock_ms = clock_ms + $urandom_range(0, adv_max);
			slot = $urandom_range(0, 7);
			src = $urandom_range(0, src_pool);
			seq = recent_seq[slot] + $urandom_range(0, 6) - 3;
			r = $urandom_range(0, 99);
			if (r < 40) begin
				kind = dfd_pkg::REQ_INSERT;
			end else if (r < 65) begin
				kind = dfd_pkg::REQ_QUERY;
				src = recent_src[slot];
				seq = recent_seq[slot];
			end else if (r < 80) begin
				kind = dfd_pkg::REQ_REMOVE;
				src = recent_src[slot];
				seq = recent_seq[slot];
			end else if (r < 85) begin
				kind = dfd_pkg::REQ_TICK;
			end else if (r < 87) begin
				kind = dfd_pkg::REQ_CLEAR;
			end else if (r < 90) begin
				kind = 3'($urandom_range(5, 7));
			end else begin
				// Noise: anything at all, including a jump of the time.
				kind = 3'($urandom_range(0, 7));
				src = $urandom;
				seq = $urandom;
				if ($urandom_range(0, 3) == 0)
					clock_ms = {$urandom, $urandom};
			end
			if (kind == dfd_pkg::REQ_INSERT) begin
				recent_src[slot] = src;
				recent_seq[slot] = seq;
			end
			send_word(kind, src, seq, clock_ms);
		end
	endtask

	initial begin
		int gap;
		m_tready = 0;
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_reply(m_tdata);
		end
	end

	initial begin
		sb = new();
		calm = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_we = 0;
		cfg_index = dfd_pkg::CFG_EXPIRY;
		cfg_wdata = '0;
		clock_ms = 64'd1000;
		for (int i = 0; i < 8; i++) begin
			recent_src[i] = i % 4;
			recent_seq[i] = 100 + i;
		end
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		write_reg(dfd_pkg::CFG_EXPIRY, 32'd100);
		write_reg(dfd_pkg::CFG_GAP, 32'd2);
		send_word(dfd_pkg::REQ_INSERT, 32'd1, 32'd10, 64'd1000);
		send_word(dfd_pkg::REQ_INSERT, 32'd1, 32'd10, 64'd1001);
		send_word(dfd_pkg::REQ_QUERY, 32'd1, 32'd10, 64'd1002);
		send_word(dfd_pkg::REQ_QUERY, 32'd1, 32'd11, 64'd1003);
		// Same source but far away in sequence: the old entry is discarded.
		send_word(dfd_pkg::REQ_INSERT, 32'd1, 32'd20, 64'd1004);
		send_word(dfd_pkg::REQ_INSERT, 32'd0, 32'd0, 64'd1005);
		send_word(dfd_pkg::REQ_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 64'd1006);
		send_word(dfd_pkg::REQ_REMOVE, 32'd0, 32'd0, 64'd1007);
		send_word(dfd_pkg::REQ_REMOVE, 32'd0, 32'd0, 64'd1008);
		send_word(3'd5, 32'd1, 32'd20, 64'd1009);
		send_word(3'd6, 32'd1, 32'd20, 64'd1009);
		send_word(3'd7, 32'd1, 32'd20, 64'd1009);
		send_word(dfd_pkg::REQ_TICK, 32'd0, 32'd0, 64'd1050);
		send_word(dfd_pkg::REQ_TICK, 32'd0, 32'd0, 64'd1200);
		send_word(dfd_pkg::REQ_INSERT, 32'd5, 32'd5, 64'd1300);
		send_word(dfd_pkg::REQ_QUERY, 32'd5, 32'd5, 64'd1500);
		// Time wraps around zero; the age still counts modulo 2^64.
		send_word(dfd_pkg::REQ_INSERT, 32'd7, 32'd7, 64'hFFFFFFFFFFFFFFF0);
		send_word(dfd_pkg::REQ_QUERY, 32'd7, 32'd7, 64'd5);
		send_word(dfd_pkg::REQ_INSERT, 32'd8, 32'd8, 64'd0);
		send_word(dfd_pkg::REQ_CLEAR, 32'd0, 32'd0, 64'd0);
		send_word(dfd_pkg::REQ_QUERY, 32'd8, 32'd8, 64'd0);
		drain();

		write_reg(dfd_pkg::CFG_EXPIRY, 32'd50);
		write_reg(dfd_pkg::CFG_GAP, 32'd4);
		random_phase(300, 6, 3);
		write_reg(dfd_pkg::CFG_EXPIRY, 32'hFFFFFFFF);
		write_reg(dfd_pkg::CFG_GAP, 32'hFFFFFFFF);
		clock_ms = 64'd5000;
		random_phase(350, 2, 40);
		write_reg(dfd_pkg::CFG_EXPIRY, 32'd0);
		write_reg(dfd_pkg::CFG_GAP, 32'd0);
		random_phase(250, 1, 3);
		write_reg(dfd_pkg::CFG_EXPIRY, $urandom_range(1, 500));
		write_reg(dfd_pkg::CFG_GAP, $urandom_range(0, 8));
		random_phase(350, 10, 5);
		write_reg(dfd_pkg::CFG_EXPIRY, 32'd1000);
		write_reg(dfd_pkg::CFG_GAP, 32'd0);
		random_phase(280, 20, 3);

		drain();
		if (sb.mismatches == 0)
			$display("PASS duplicate_frame_detector");
		else
			$display("FAIL duplicate_frame_detector");
		$finish;
	end
endmodule
